// File: rtl/core/gsa_pkg.sv
// Package for the generational slot allocator: sizes, op codes, state type
// and the command and status structs shared by controller and datapath.
// No dependencies.
package gsa_pkg;

  localparam int SlotCount = 32;
  localparam int SlotW     = $clog2(SlotCount);
  localparam int SpanLimit = 128;
  localparam int AreaLimit = 8192;
  localparam int AreaW     = 14;
  localparam int CellW     = 19;
  localparam int CountW    = 6;
  localparam int GenW      = 16;
  localparam int BudgetW   = 7;
  localparam logic [BudgetW-1:0] BudgetReset = 7'd40;
  localparam logic [GenW-1:0]    FirstGen    = 16'd1;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_WAKE  = 3'd2,
    OP_QUERY = 3'd3,
    OP_SLEEP = 3'd4,
    OP_RESET = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
    logic sweep;
    logic clear_counts;
    logic show;
  } gsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_reset;
    logic sweep_last;
  } gsa_sts_t;

endpackage

// File: rtl/core/gsa_ctrl.sv
// Controller of the slot allocator: sequences capture, lookup, execute and the
// reset-all sweep, and runs the result handshake. Depends on gsa_pkg.
module gsa_ctrl import gsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gsa_sts_t sts,
  output gsa_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = sts.is_reset ? ST_SWEEP : ST_EXEC;
      ST_EXEC:  state_nxt = ST_DONE;
      ST_SWEEP: if (sts.sweep_last) state_nxt = ST_DONE;
      ST_DONE:  if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOK:  cmd.look = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_SWEEP: begin
        cmd.sweep        = 1'b1;
        cmd.clear_counts = sts.sweep_last;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        cmd.show  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/core/gsa_dp.sv
// Datapath of the slot allocator: slot state, area memory, counters, peaks
// and the result register. Depends on gsa_pkg.
module gsa_dp import gsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  gsa_cmd_t           cmd,
  output gsa_sts_t           sts,
  input  logic               cfg_we,
  input  logic [BudgetW-1:0] cfg_data,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_slot_index,
  input  logic [15:0]        in_handle_generation,
  input  logic [9:0]         in_body_width,
  input  logic [9:0]         in_body_height,
  output logic               out_ok,
  output logic [4:0]         out_index,
  output logic [15:0]        out_generation,
  output logic               out_is_awake,
  output logic [5:0]         out_live_count,
  output logic [5:0]         out_awake_total,
  output logic [18:0]        out_cells_allocated,
  output logic [31:0]        out_alloc_failures,
  output logic [31:0]        out_budget_refusals,
  output logic [5:0]         out_peak_live,
  output logic [5:0]         out_peak_awake,
  output logic [18:0]        out_peak_cells
);

  // Request registers.
  logic [2:0]  op_r;
  logic [15:0] idx_r, gen_r;
  logic [9:0]  w_r, h_r;
  logic [19:0] area_r;

  // Slot state. Generations hold the stored value minus one so reset is zero.
  logic [SlotCount-1:0] live_r, awake_r;
  logic [GenW-1:0]      genm_r [SlotCount];
  logic [AreaW-1:0]     area_mem [SlotCount];
  logic [AreaW-1:0]     area_rd_r;

  logic [CountW-1:0]  live_cnt_r, awake_cnt_r, peak_live_r, peak_awake_r;
  logic [CellW-1:0]   cells_r, peak_cells_r;
  logic [31:0]        fail_r, refuse_r;
  logic [BudgetW-1:0] budget_r;

  // Lookup results.
  logic             hl_r, size_ok_r, free_found_r;
  logic [SlotW-1:0] slot_r, free_r;
  logic [SlotW-1:0] sweep_r;
  logic             ok_r, awk_r;
  logic [SlotW-1:0] oidx_r;
  logic [GenW-1:0]  ogen_r;

  logic [SlotW-1:0] idx_s;
  logic             idx_in;
  logic             free_any;
  logic [SlotW-1:0] free_enc;

  assign idx_in = (idx_r < 16'(SlotCount));
  assign idx_s  = idx_r[SlotW-1:0];

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_enc = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_any = 1'b1;
        free_enc = SlotW'(i);
      end
    end
  end

  assign sts.is_reset   = (op_r == OP_RESET);
  assign sts.sweep_last = (sweep_r == SlotW'(SlotCount - 1));

  function automatic logic [GenW-1:0] gen_of(input logic [GenW-1:0] m);
    return m + FirstGen;
  endfunction

  // Capture and lookup.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      idx_r  <= in_slot_index;
      gen_r  <= in_handle_generation;
      w_r    <= in_body_width;
      h_r    <= in_body_height;
      area_r <= in_body_width * in_body_height;
    end
    if (cmd.look) begin
      hl_r <= idx_in && gen_r != '0 && live_r[idx_s] && gen_of(genm_r[idx_s]) == gen_r;
      size_ok_r <= w_r != '0 && h_r != '0 && w_r <= 10'(SpanLimit)
                   && h_r <= 10'(SpanLimit) && area_r <= 20'(AreaLimit);
      free_found_r <= free_any;
      free_r       <= free_enc;
      slot_r       <= idx_s;
      area_rd_r    <= area_mem[idx_s];
    end
  end

  // Area memory: written on alloc, read at lookup.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == OP_ALLOC && size_ok_r && free_found_r)
      area_mem[free_r] <= area_r[AreaW-1:0];
  end

  logic [CellW:0] cell_sum;
  assign cell_sum = {1'b0, cells_r} + (CellW+1)'(area_r);

  // Execute, sweep and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      awake_r      <= '0;
      for (int i = 0; i < SlotCount; i++) genm_r[i] <= '0;
      live_cnt_r   <= '0;
      awake_cnt_r  <= '0;
      cells_r      <= '0;
      fail_r       <= '0;
      refuse_r     <= '0;
      peak_live_r  <= '0;
      peak_awake_r <= '0;
      peak_cells_r <= '0;
      budget_r     <= BudgetReset;
      sweep_r      <= '0;
    end else begin
      if (cfg_we) budget_r <= cfg_data;
      if (cmd.capture) sweep_r <= '0;
      if (cmd.exec) begin
        ok_r   <= 1'b0;
        awk_r  <= 1'b0;
        oidx_r <= '0;
        ogen_r <= '0;
        unique case (op_r)
          OP_ALLOC: begin
            if (!(size_ok_r && free_found_r)) begin
              if (fail_r != '1) fail_r <= fail_r + 32'd1;
            end else begin
              live_r[free_r] <= 1'b1;
              if ({1'b0, awake_cnt_r} < budget_r) begin
                awake_r[free_r] <= 1'b1;
                awake_cnt_r     <= awake_cnt_r + 1'b1;
                if (awake_cnt_r + 1'b1 > peak_awake_r) peak_awake_r <= awake_cnt_r + 1'b1;
                awk_r <= 1'b1;
              end else begin
                awake_r[free_r] <= 1'b0;
                if (refuse_r != '1) refuse_r <= refuse_r + 32'd1;
              end
              live_cnt_r <= live_cnt_r + 1'b1;
              if (live_cnt_r + 1'b1 > peak_live_r) peak_live_r <= live_cnt_r + 1'b1;
              if (cell_sum[CellW]) begin
                cells_r <= '1;
                peak_cells_r <= '1;
              end else begin
                cells_r <= cell_sum[CellW-1:0];
                if (cell_sum[CellW-1:0] > peak_cells_r) peak_cells_r <= cell_sum[CellW-1:0];
              end
              ok_r   <= 1'b1;
              oidx_r <= 5'(free_r);
              ogen_r <= gen_of(genm_r[free_r]);
            end
          end
          OP_FREE: begin
            if (hl_r) begin
              cells_r <= ({5'd0, area_rd_r} >= cells_r) ? '0
                         : cells_r - CellW'(area_rd_r);
              if (live_cnt_r != '0) live_cnt_r <= live_cnt_r - 1'b1;
              if (awake_r[slot_r] && awake_cnt_r != '0) awake_cnt_r <= awake_cnt_r - 1'b1;
              live_r[slot_r]  <= 1'b0;
              awake_r[slot_r] <= 1'b0;
              genm_r[slot_r]  <= (genm_r[slot_r] == 16'hFFFE) ? '0 : genm_r[slot_r] + 1'b1;
              ok_r <= 1'b1;
            end
          end
          OP_WAKE: begin
            if (hl_r) begin
              if (awake_r[slot_r]) begin
                ok_r  <= 1'b1;
                awk_r <= 1'b1;
              end else if ({1'b0, awake_cnt_r} >= budget_r) begin
                if (refuse_r != '1) refuse_r <= refuse_r + 32'd1;
              end else begin
                awake_r[slot_r] <= 1'b1;
                awake_cnt_r     <= awake_cnt_r + 1'b1;
                if (awake_cnt_r + 1'b1 > peak_awake_r) peak_awake_r <= awake_cnt_r + 1'b1;
                ok_r  <= 1'b1;
                awk_r <= 1'b1;
              end
            end
          end
          OP_QUERY: begin
            ok_r  <= hl_r;
            awk_r <= hl_r && awake_r[slot_r];
          end
          OP_SLEEP: begin
            if (hl_r) begin
              if (awake_r[slot_r]) begin
                awake_r[slot_r] <= 1'b0;
                if (awake_cnt_r != '0) awake_cnt_r <= awake_cnt_r - 1'b1;
              end
              ok_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Reset-all sweep: one slot a beat-free cycle.
      if (cmd.sweep) begin
        if (live_r[sweep_r]) begin
          live_r[sweep_r]  <= 1'b0;
          awake_r[sweep_r] <= 1'b0;
          genm_r[sweep_r]  <= (genm_r[sweep_r] == 16'hFFFE) ? '0 : genm_r[sweep_r] + 1'b1;
        end
        sweep_r <= sweep_r + 1'b1;
        ok_r   <= 1'b1;
        awk_r  <= 1'b0;
        oidx_r <= '0;
        ogen_r <= '0;
      end
      if (cmd.clear_counts) begin
        live_cnt_r  <= '0;
        awake_cnt_r <= '0;
        cells_r     <= '0;
      end
    end
  end

  // Result fields.
  assign out_ok              = ok_r;
  assign out_index           = oidx_r;
  assign out_generation      = ogen_r;
  assign out_is_awake        = awk_r;
  assign out_live_count      = live_cnt_r;
  assign out_awake_total     = awake_cnt_r;
  assign out_cells_allocated = cells_r;
  assign out_alloc_failures  = fail_r;
  assign out_budget_refusals = refuse_r;
  assign out_peak_live       = peak_live_r;
  assign out_peak_awake      = peak_awake_r;
  assign out_peak_cells      = peak_cells_r;

endmodule

// File: rtl/core/generational_slot_allocator_core.sv
// Generational slot allocator core: pool of 32 body slots named by handles.
// Each request is captured, looked up and executed before its result is shown;
// reset-all replaces execute with a sweep that visits one slot per cycle.
// Throughput: one request in flight; a new request is taken only after the result is accepted.
// Reset: synchronous active-low rst_n clears all slots, counts and peaks,
// and sets the awake budget to 40.
module generational_slot_allocator_core import gsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_slot_index,
  input  logic [15:0] in_handle_generation,
  input  logic [9:0]  in_body_width,
  input  logic [9:0]  in_body_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [4:0]  out_index,
  output logic [15:0] out_generation,
  output logic        out_is_awake,
  output logic [5:0]  out_live_count,
  output logic [5:0]  out_awake_total,
  output logic [18:0] out_cells_allocated,
  output logic [31:0] out_alloc_failures,
  output logic [31:0] out_budget_refusals,
  output logic [5:0]  out_peak_live,
  output logic [5:0]  out_peak_awake,
  output logic [18:0] out_peak_cells
);

  gsa_cmd_t cmd;
  gsa_sts_t sts;

  gsa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  gsa_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_data,
    .in_op, .in_slot_index, .in_handle_generation, .in_body_width, .in_body_height,
    .out_ok, .out_index, .out_generation, .out_is_awake, .out_live_count,
    .out_awake_total, .out_cells_allocated, .out_alloc_failures,
    .out_budget_refusals, .out_peak_live, .out_peak_awake, .out_peak_cells
  );

  // Never take a new beat while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // Live count never exceeds the pool size.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= 6'(SlotCount)) else $error("live count overflow");

  // Awake bodies are never more than live ones.
  a_awake_le_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_awake_total <= out_live_count) else $error("awake above live");

  // A failed request reports generation zero.
  a_fail_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> out_generation == 16'd0) else $error("bad generation");

endmodule
